### rtl/qrm_pkg.sv
// Shared types, widths and term tables for the quaternion column rotation datapath.
`default_nettype none

package qrm_pkg;

    localparam int WORD_W = 32;   // Q1.30 quaternion and Q15.16 vector words
    localparam int PROD_W = 64;   // one quaternion by vector product
    localparam int ACC3_W = 66;   // sum of three such products
    localparam int FRAC_Q = 30;   // fraction bits of the quaternion
    localparam int P_W    = 36;   // intermediate quaternion component, Q.16
    localparam int PL_W   = 16;   // low part of a p component
    localparam int PH_W   = P_W - PL_W;
    localparam int HI_W   = WORD_W + PH_W;          // q * high part of p
    localparam int LO_W   = WORD_W + PL_W + 1;      // q * low part of p
    localparam int SHI_W  = HI_W + 2;               // four high products
    localparam int SLO_W  = LO_W + 2;               // four low products
    localparam int TOT_W  = SHI_W + 1;
    localparam int HI_SH  = FRAC_Q - PL_W;          // remaining shift after the split
    localparam int RES_W  = TOT_W - HI_SH;

    localparam int N_COMP = 3;
    localparam int N_QC   = 4;   // x, y, z, w
    localparam int N_TERM = 4;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC3_W-1:0] acc3_t;
    typedef logic signed [P_W-1:0]    pcomp_t;
    typedef logic signed [PH_W-1:0]   phi_t;
    typedef logic signed [HI_W-1:0]   hi_t;
    typedef logic signed [LO_W-1:0]   lo_t;
    typedef logic signed [SHI_W-1:0]  shi_t;
    typedef logic signed [SLO_W-1:0]  slo_t;
    typedef logic signed [TOT_W-1:0]  tot_t;
    typedef logic signed [RES_W-1:0]  res_t;
    typedef logic [1:0]               qsel_t;

    localparam qsel_t QX = 2'd0;
    localparam qsel_t QY = 2'd1;
    localparam qsel_t QZ = 2'd2;
    localparam qsel_t QW = 2'd3;

    // Second product p * conj(q): which q and which p component feed each term.
    localparam qsel_t COEF_SEL [N_COMP][N_TERM] = '{
        '{QY, QZ, QX, QW},
        '{QZ, QX, QY, QW},
        '{QX, QY, QZ, QW}
    };
    localparam qsel_t PCOMP_SEL [N_COMP][N_TERM] = '{
        '{QZ, QY, QW, QX},
        '{QX, QZ, QW, QY},
        '{QY, QX, QW, QZ}
    };
    // The middle two terms of every rotated component are subtracted.
    localparam logic [N_TERM-1:0] TERM_NEG = 4'b0110;

endpackage

`default_nettype wire

### rtl/qrm_if.sv
// Valid/ready channel interfaces for input columns and rotated results.
`default_nettype none

interface qrm_in_if;
    import qrm_pkg::*;

    logic  valid;
    logic  ready;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t quat_w;
    word_t col_x;
    word_t col_y;
    word_t col_z;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, output col_x, output col_y, output col_z,
                    input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, input col_x, input col_y, input col_z,
                    output ready);
endinterface

interface qrm_out_if;
    import qrm_pkg::*;

    logic  valid;
    logic  ready;
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
    logic  clipped;

    modport source (output valid, output rot_x, output rot_y, output rot_z,
                    output clipped, input ready);
    modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                    input clipped, output ready);
endinterface

`default_nettype wire

### rtl/quaternion_rotate_matrix_column.sv
// Five register stages each carry a valid bit; an accepted word passes through them in order.
// Throughput: one column word per cycle while the output is not stalled.
// Each stage holds its word while stalled and fills a bubble below it, so the input keeps
// accepting while a finished result waits, as long as some stage is empty.
// Reset (rst_n low, asynchronous) clears every valid bit; the datapath registers are not reset.
`default_nettype none

module quaternion_rotate_matrix_column (
    input  logic             clk,
    input  logic             rst_n,
    qrm_in_if.sink           column,
    qrm_out_if.source        rotated
);
    import qrm_pkg::*;

    // The datapath computes q * v * conj(q) in two product passes.
    // Stage 1 forms the twelve 32x32 products of q with the column.
    // Stage 2 sums them in threes and drops 30 fraction bits, giving p = q * (v, 0).
    // Stage 3 multiplies q by p, with each p component split at bit 16 so that
    // no multiplier is wider than 32 bits.
    // Stage 4 sums the high and low partial products of each rotated component.
    // Stage 5 recombines them, drops the rest of the fraction and saturates to 32 bits.

    // Valid bits and stage advance.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // A stage may load when it is empty or when the stage after it is loading.
    assign rdy5 = !v5_reg || rotated.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign column.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= column.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Stage 1: products of q and the column, grouped by the p component they feed.
    // Row order is px, py, pz, pw.
    prod_t prod_reg  [N_QC][3];
    prod_t prod_next [N_QC][3];
    word_t q1_reg    [N_QC];
    word_t q1_next   [N_QC];

    always_comb
    begin
        q1_next[QX] = column.quat_x;
        q1_next[QY] = column.quat_y;
        q1_next[QZ] = column.quat_z;
        q1_next[QW] = column.quat_w;

        prod_next[QX][0] = prod_t'(column.quat_y) * prod_t'(column.col_z);
        prod_next[QX][1] = prod_t'(column.quat_z) * prod_t'(column.col_y);
        prod_next[QX][2] = prod_t'(column.quat_w) * prod_t'(column.col_x);

        prod_next[QY][0] = prod_t'(column.quat_z) * prod_t'(column.col_x);
        prod_next[QY][1] = prod_t'(column.quat_x) * prod_t'(column.col_z);
        prod_next[QY][2] = prod_t'(column.quat_w) * prod_t'(column.col_y);

        prod_next[QZ][0] = prod_t'(column.quat_x) * prod_t'(column.col_y);
        prod_next[QZ][1] = prod_t'(column.quat_y) * prod_t'(column.col_x);
        prod_next[QZ][2] = prod_t'(column.quat_w) * prod_t'(column.col_z);

        prod_next[QW][0] = prod_t'(column.quat_x) * prod_t'(column.col_x);
        prod_next[QW][1] = prod_t'(column.quat_y) * prod_t'(column.col_y);
        prod_next[QW][2] = prod_t'(column.quat_z) * prod_t'(column.col_z);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && column.valid)
        begin
            prod_reg <= prod_next;
            q1_reg   <= q1_next;
        end
    end

    // Stage 2: the intermediate quaternion p. The sums are exact and the shift
    // by 30 rounds toward minus infinity.
    pcomp_t p_reg  [N_QC];
    pcomp_t p_next [N_QC];
    word_t  q2_reg [N_QC];
    acc3_t  acc    [N_QC];

    always_comb
    begin
        acc[QX] = acc3_t'(prod_reg[QX][0]) - acc3_t'(prod_reg[QX][1])
                + acc3_t'(prod_reg[QX][2]);
        acc[QY] = acc3_t'(prod_reg[QY][0]) - acc3_t'(prod_reg[QY][1])
                + acc3_t'(prod_reg[QY][2]);
        acc[QZ] = acc3_t'(prod_reg[QZ][0]) - acc3_t'(prod_reg[QZ][1])
                + acc3_t'(prod_reg[QZ][2]);
        acc[QW] = -acc3_t'(prod_reg[QW][0]) - acc3_t'(prod_reg[QW][1])
                - acc3_t'(prod_reg[QW][2]);
        for (int i = 0; i < N_QC; i++)
        begin
            p_next[i] = pcomp_t'(acc[i][ACC3_W-1:FRAC_Q]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            p_reg  <= p_next;
            q2_reg <= q1_reg;
        end
    end

    // Stage 3: partial products of q with the high and low halves of p.
    // The low half is an unsigned 16-bit value, so it enters with a zero sign bit.
    hi_t hi_reg  [N_COMP][N_TERM];
    hi_t hi_next [N_COMP][N_TERM];
    lo_t lo_reg  [N_COMP][N_TERM];
    lo_t lo_next [N_COMP][N_TERM];

    always_comb
    begin
        for (int k = 0; k < N_COMP; k++)
        begin
            for (int j = 0; j < N_TERM; j++)
            begin
                hi_next[k][j] = hi_t'(q2_reg[COEF_SEL[k][j]])
                              * hi_t'(phi_t'(p_reg[PCOMP_SEL[k][j]][P_W-1:PL_W]));
                lo_next[k][j] = lo_t'(q2_reg[COEF_SEL[k][j]])
                              * lo_t'({1'b0, p_reg[PCOMP_SEL[k][j]][PL_W-1:0]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // Stage 4: signed sums of the four terms, kept apart for the high and low halves.
    shi_t shi_reg  [N_COMP];
    shi_t shi_next [N_COMP];
    slo_t slo_reg  [N_COMP];
    slo_t slo_next [N_COMP];

    always_comb
    begin
        for (int k = 0; k < N_COMP; k++)
        begin
            shi_next[k] = '0;
            slo_next[k] = '0;
            for (int j = 0; j < N_TERM; j++)
            begin
                if (TERM_NEG[j])
                begin
                    shi_next[k] = shi_next[k] - shi_t'(hi_reg[k][j]);
                    slo_next[k] = slo_next[k] - slo_t'(lo_reg[k][j]);
                end
                else
                begin
                    shi_next[k] = shi_next[k] + shi_t'(hi_reg[k][j]);
                    slo_next[k] = slo_next[k] + slo_t'(lo_reg[k][j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            shi_reg <= shi_next;
            slo_reg <= slo_next;
        end
    end

    // Stage 5: floor(shi + floor(slo / 2^16)) / 2^14 equals the exact floor of the
    // full sum by 2^30. A result whose bits above bit 31 are not all copies of the
    // sign is clamped to the nearest 32-bit bound.
    word_t rot_reg  [N_COMP];
    word_t rot_next [N_COMP];
    logic  clip_reg;
    logic  clip_next;
    tot_t  tot      [N_COMP];
    res_t  res      [N_COMP];
    logic  ovf      [N_COMP];

    always_comb
    begin
        clip_next = 1'b0;
        for (int k = 0; k < N_COMP; k++)
        begin
            tot[k] = tot_t'(shi_reg[k]) + tot_t'(slo_reg[k] >>> PL_W);
            res[k] = res_t'(tot[k][TOT_W-1:HI_SH]);
            ovf[k] = (res[k][RES_W-1:WORD_W-1] != '0) && (res[k][RES_W-1:WORD_W-1] != '1);
            if (ovf[k])
            begin
                rot_next[k] = res[k][RES_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                              : {1'b0, {(WORD_W-1){1'b1}}};
            end
            else
            begin
                rot_next[k] = word_t'(res[k][WORD_W-1:0]);
            end
            clip_next = clip_next | ovf[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign rotated.valid   = v5_reg;
    assign rotated.rot_x   = rot_reg[0];
    assign rotated.rot_y   = rot_reg[1];
    assign rotated.rot_z   = rot_reg[2];
    assign rotated.clipped = clip_reg;

`ifndef SYNTHESIS
    // An accepted word always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (column.valid && column.ready) |=> v1_reg)
        else $error("accepted word did not enter the first stage");

    // A new result can only come from a valid word in the fourth stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v5_reg) |-> $past(v4_reg))
        else $error("result appeared without a word in the fourth stage");

    // With every stage full and the output stalled, the input must not accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !rotated.ready)
            |-> !column.ready)
        else $error("input accepted while the pipeline was full and stalled");

    // A stalled third stage holding a word keeps it on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy4) |=> v3_reg)
        else $error("third stage dropped a stalled word");
`endif

endmodule

`default_nettype wire
